>>> design/message_throttle_coalescer_unit_macros.svh
// assertion macros for the message throttle coalescer
`ifndef MESSAGE_THROTTLE_COALESCER_UNIT_MACROS_SVH
`define MESSAGE_THROTTLE_COALESCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define MTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication, checked out of reset
`define MTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MTC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> design/mtc_pkg.sv
// shared types and constants for the message throttle coalescer
package mtc_pkg;

	localparam int ELAPSED_BITS_DEF = 16;
	localparam int INTERVAL_W       = 16;
	localparam int APB_DATA_W       = 32;
	localparam int APB_ADDR_W       = 3;

	// register index, taken from paddr bit 2
	localparam logic REG_INTERVAL = 1'b0;

	// input beat kinds
	localparam logic [1:0] KIND_MSG   = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_PURGE = 2'd2;

	typedef struct packed {
		logic [7:0]  mtype;
		logic [15:0] id;
		logic [15:0] dest;
		logic [31:0] handle;
	} msg_t;

	typedef struct packed {
		logic valid;
		logic held;
		msg_t msg;
	} res_t;

	typedef struct packed {
		logic                  wr;
		logic [INTERVAL_W-1:0] interval;
	} cfg_t;

endpackage

>>> design/message_throttle_coalescer_unit.sv
// top level of the message throttle coalescer
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  kind, msg_type, msg_id, msg_dest, msg_handle
//  output    out        out_valid/out_stall  out_type, out_id, out_dest, out_handle,
//                                            out_was_held
//  config    in         apb psel/penable     interval_ticks at byte address 0
//
// one beat per cycle while the input is not stalled: a beat is registered in the input
// stage, where the throttle decision and the state update happen, then its result (if
// any) lands in the output register, which drives out_valid
// reset clears the stage valids, the pending flag and the interval, and pins the
// elapsed counter at its max so the first message passes at once
// a stalled output only blocks the input stage when that stage has a result to hand over
module message_throttle_coalescer_unit #(
	parameter int ELAPSED_BITS = mtc_pkg::ELAPSED_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      kind,
	input  logic [7:0]                      msg_type,
	input  logic [15:0]                     msg_id,
	input  logic [15:0]                     msg_dest,
	input  logic [31:0]                     msg_handle,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_type,
	output logic [15:0]                     out_id,
	output logic [15:0]                     out_dest,
	output logic [31:0]                     out_handle,
	output logic                            out_was_held,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mtc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [mtc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [mtc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import mtc_pkg::*;

	cfg_t cfg;
	msg_t in_msg;
	res_t res;
	logic adv;
	logic out_free;
	logic out_load;

	// output register state
	logic out_valid_q;
	logic out_held_q;
	msg_t out_msg_q;

	mtc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_msg.mtype  = msg_type;
	assign in_msg.id     = msg_id;
	assign in_msg.dest   = msg_dest;
	assign in_msg.handle = msg_handle;

	// the output register can take a new beat when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	mtc_core #(
		.ELAPSED_BITS (ELAPSED_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.in_msg   (in_msg),
		.cfg      (cfg),
		.out_free (out_free),
		.res      (res),
		.adv      (adv)
	);

	assign out_load = adv && res.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only moves when a new result is loaded
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_msg_q  <= res.msg;
			out_held_q <= res.held;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_type     = out_msg_q.mtype;
	assign out_id       = out_msg_q.id;
	assign out_dest     = out_msg_q.dest;
	assign out_handle   = out_msg_q.handle;
	assign out_was_held = out_held_q;

endmodule

>>> design/mtc_cfg.sv
// apb configuration register block
module mtc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mtc_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [mtc_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [mtc_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output mtc_pkg::cfg_t                   cfg
);
	import mtc_pkg::*;

	logic [INTERVAL_W-1:0] interval_q;
	logic                  reg_sel;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_INTERVAL);
	assign wr_en   = psel && penable && pwrite && pready && reg_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= '0;
		end else if (wr_en) begin
			interval_q <= pwdata[INTERVAL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = APB_DATA_W'(interval_q);
		end
	end

	assign cfg.wr       = wr_en;
	assign cfg.interval = interval_q;

endmodule

>>> design/mtc_core.sv
// input stage, throttle state and emit decision
`include "message_throttle_coalescer_unit_macros.svh"
module mtc_core #(
	parameter int ELAPSED_BITS = mtc_pkg::ELAPSED_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [1:0]    kind,
	input  mtc_pkg::msg_t in_msg,
	input  mtc_pkg::cfg_t cfg,
	input  logic          out_free,
	output mtc_pkg::res_t res,
	output logic          adv
);
	import mtc_pkg::*;

	localparam int CMP_W = (ELAPSED_BITS > INTERVAL_W) ? ELAPSED_BITS : INTERVAL_W;

	logic                    valid_s1;
	logic [1:0]              kind_s1;
	msg_t                    msg_s1;

	logic [ELAPSED_BITS-1:0] elapsed_q;
	logic [ELAPSED_BITS-1:0] elapsed_d;
	logic [ELAPSED_BITS-1:0] elapsed_inc;
	logic                    pend_valid_q;
	logic                    pend_valid_d;
	logic                    pend_load;
	msg_t                    pend_q;

	logic                    in_acc;
	logic                    ok_now;
	logic                    ok_inc;
	logic                    key_diff;

	assign in_acc   = in_valid && !in_stall;
	assign adv      = valid_s1 && (!res.valid || out_free);
	assign in_stall = valid_s1 && !adv;

	// interval elapsed, or counter pinned at its max
	assign ok_now = (CMP_W'(elapsed_q) >= CMP_W'(cfg.interval)) || (&elapsed_q);
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + ELAPSED_BITS'(1);
	assign ok_inc = (CMP_W'(elapsed_inc) >= CMP_W'(cfg.interval)) || (&elapsed_inc);

	assign key_diff = (pend_q.mtype != msg_s1.mtype) || (pend_q.id != msg_s1.id) ||
	                  (pend_q.dest != msg_s1.dest);

	always_comb begin
		res.valid    = 1'b0;
		res.held     = 1'b0;
		res.msg      = msg_s1;
		elapsed_d    = elapsed_q;
		pend_valid_d = pend_valid_q;
		pend_load    = 1'b0;
		if (valid_s1) begin
			case (kind_s1)
				KIND_MSG: begin
					if (cfg.interval == '0 || ok_now) begin
						res.valid = 1'b1;
						elapsed_d = '0;
					end else begin
						if (pend_valid_q && key_diff) begin
							res.valid = 1'b1;
							res.held  = 1'b1;
							res.msg   = pend_q;
							elapsed_d = '0;
						end
						pend_valid_d = 1'b1;
						pend_load    = 1'b1;
					end
				end
				KIND_TICK: begin
					elapsed_d = elapsed_inc;
					if (pend_valid_q && ok_inc) begin
						res.valid    = 1'b1;
						res.held     = 1'b1;
						res.msg      = pend_q;
						elapsed_d    = '0;
						pend_valid_d = 1'b0;
					end
				end
				KIND_PURGE: begin
					pend_valid_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_s1 <= kind;
			msg_s1  <= in_msg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q    <= '1;
			pend_valid_q <= 1'b0;
		end else begin
			if (cfg.wr) begin
				elapsed_q <= '1;
			end else if (adv) begin
				elapsed_q <= elapsed_d;
			end
			if (adv) begin
				pend_valid_q <= pend_valid_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pend_load) begin
			pend_q <= msg_s1;
		end
	end

	// any emitted beat restarts the interval
	`MTC_ASSERT_NXT(a_emit_clears_count, clk, arst_n, adv && res.valid && !cfg.wr,
		elapsed_q == '0)
	// a blocked result keeps its item in the input stage
	`MTC_ASSERT_NXT(a_blocked_item_holds, clk, arst_n, valid_s1 && res.valid && !out_free,
		valid_s1 && $stable(msg_s1) && $stable(pend_valid_q))
	// purge always leaves the slot empty
	`MTC_ASSERT_NXT(a_purge_empties, clk, arst_n, adv && kind_s1 == KIND_PURGE,
		!pend_valid_q)
	// a held release needs a pending message
	`MTC_ASSERT_IMP(a_held_needs_pending, clk, arst_n, res.valid && res.held,
		pend_valid_q)

endmodule

>>> dv/testbench.sv
// self-checking testbench for the message throttle coalescer
`timescale 1ns / 100ps

module testbench;
	import mtc_pkg::*;

	localparam int ELAPSED_BITS = ELAPSED_BITS_DEF;
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_SAT = '1;
	// the one kind code that the package leaves unnamed; the block must ignore it
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam logic [APB_ADDR_W-1:0] ADDR_INTERVAL = 3'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;
	localparam int PHASES = 10;
	localparam int BEATS_PER_PHASE = 75;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int LIMIT = 300000;

	typedef struct packed {
		logic [1:0] kind;
		msg_t       msg;
	} beat_t;

	typedef struct packed {
		logic held;
		msg_t msg;
	} fwd_t;

	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            kind = '0;
	logic [7:0]            msg_type = '0;
	logic [15:0]           msg_id = '0;
	logic [15:0]           msg_dest = '0;
	logic [31:0]           msg_handle = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [7:0]            out_type;
	logic [15:0]           out_id;
	logic [15:0]           out_dest;
	logic [31:0]           out_handle;
	logic                  out_was_held;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	message_throttle_coalescer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .msg_type(msg_type),
		.msg_id(msg_id), .msg_dest(msg_dest), .msg_handle(msg_handle),
		.out_valid(out_valid), .out_stall(out_stall), .out_type(out_type), .out_id(out_id),
		.out_dest(out_dest), .out_handle(out_handle), .out_was_held(out_was_held),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// throttle predictor: its own copy of the interval, the elapsed
	// counter and the single held message
	// ---------------------------------------------------------------
	logic [INTERVAL_W-1:0]   interval_q = '0;
	logic [ELAPSED_BITS-1:0] elapsed_q = ELAPSED_SAT;
	logic                    hold_valid = 1'b0;
	msg_t                    hold_msg = '0;
	fwd_t                    fwd_expect[$];
	beat_t                   beat_q[$];

	int errors = 0;
	int n_beats = 0;
	int n_results = 0;
	int n_direct = 0;
	int n_held = 0;
	int n_cfg = 0;
	int n_backpressure = 0;

	// saturation counts as elapsed so that an interval at the counter's max still expires
	function automatic logic interval_met();
		return (elapsed_q >= interval_q) || (elapsed_q == ELAPSED_SAT);
	endfunction

	// every forwarded message restarts the interval
	function automatic void forward(msg_t m, logic held);
		fwd_t f;
		f.held = held;
		f.msg = m;
		fwd_expect.push_back(f);
		elapsed_q = '0;
		if (held)
			n_held++;
		else
			n_direct++;
	endfunction

	function automatic void throttle_step(logic [1:0] k, msg_t m);
		case (k)
			KIND_MSG: begin
				if (interval_q == '0 || interval_met()) begin
					// direct pass leaves any held message where it is
					forward(m, 1'b0);
				end else begin
					// a held message with another key goes out first, a duplicate is overwritten
					if (hold_valid && (hold_msg.mtype != m.mtype || hold_msg.id != m.id ||
							hold_msg.dest != m.dest))
						forward(hold_msg, 1'b1);
					hold_valid = 1'b1;
					hold_msg = m;
				end
			end
			KIND_TICK: begin
				if (elapsed_q != ELAPSED_SAT)
					elapsed_q++;
				if (hold_valid && interval_met()) begin
					hold_valid = 1'b0;
					forward(hold_msg, 1'b1);
				end
			end
			KIND_PURGE: begin
				// drops the held message, counter untouched
				hold_valid = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// sender: bursts of random length with random gaps, fed from beat_q;
	// the prediction runs at the edge where a beat is accepted
	// ---------------------------------------------------------------
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin : sender
		beat_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				throttle_step(kind, {msg_type, msg_id, msg_dest, msg_handle});
				n_beats++;
			end
			if (in_valid && in_stall) begin
				// stalled beat holds its payload
				n_backpressure++;
			end else if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (beat_q.size() != 0) begin
				nxt = beat_q.pop_front();
				in_valid <= 1'b1;
				kind <= nxt.kind;
				msg_type <= nxt.msg.mtype;
				msg_id <= nxt.msg.id;
				msg_dest <= nxt.msg.dest;
				msg_handle <= nxt.msg.handle;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 30);
					// a quarter of the bursts run straight into the next one
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: a random stall pattern, redrawn whenever its random span runs out; a long
	// hold-off is served whenever the stimulus asks for one
	// ---------------------------------------------------------------
	int          hold_requests = 0;
	int          holds_served = 0;
	int          hold_left = 0;
	int          mode_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always @(posedge clk) begin : receiver
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					STALL_NONE:   out_stall <= 1'b0;
					STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
					STALL_TOGGLE: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// ---------------------------------------------------------------
	// result checker: each accepted beat against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin : result_check
		fwd_t e;
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (fwd_expect.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: type %h id %h dest %h handle %h held %b",
						out_type, out_id, out_dest, out_handle, out_was_held);
			end else begin
				e = fwd_expect.pop_front();
				if (out_type !== e.msg.mtype || out_id !== e.msg.id || out_dest !== e.msg.dest ||
						out_handle !== e.msg.handle || out_was_held !== e.held) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: exp type %h id %h dest %h handle %h held %b",
							e.msg.mtype, e.msg.id, e.msg.dest, e.msg.handle, e.held);
						$display("          got type %h id %h dest %h handle %h held %b",
							out_type, out_id, out_dest, out_handle, out_was_held);
					end
				end
			end
		end
	end

	// run limit
	int cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	msg_t key_pool[4];

	function automatic beat_t mk(logic [1:0] k, logic [7:0] t, logic [15:0] id,
			logic [15:0] d, logic [31:0] h);
		beat_t b;
		b.kind = k;
		b.msg.mtype = t;
		b.msg.id = id;
		b.msg.dest = d;
		b.msg.handle = h;
		return b;
	endfunction

	function automatic msg_t random_msg();
		msg_t m;
		m.mtype = 8'($urandom_range(0, 255));
		m.id = 16'($urandom_range(0, 65535));
		m.dest = 16'($urandom_range(0, 65535));
		m.handle = $urandom;
		return m;
	endfunction

	// messages mostly come from a small key pool so duplicates keep hitting the held slot
	function automatic beat_t random_beat();
		beat_t b;
		int r;
		r = $urandom_range(0, 99);
		b.msg = random_msg();
		if (r < 46)
			b.kind = KIND_MSG;
		else if (r < 86)
			b.kind = KIND_TICK;
		else if (r < 94)
			b.kind = KIND_PURGE;
		else
			b.kind = KIND_UNUSED;
		if (b.kind == KIND_MSG && $urandom_range(0, 4) != 0) begin
			b.msg = key_pool[2'($urandom_range(0, 3))];
			b.msg.handle = $urandom;
		end
		return b;
	endfunction

	// wait until every beat is in and every result out, then let the pipe empty
	task automatic settle();
		do @(negedge clk);
		while (beat_q.size() != 0 || in_valid || fwd_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data,
			output logic [APB_DATA_W-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// write, mirror into the predictor, then read the interval back
	task automatic set_interval(logic [APB_ADDR_W-1:0] addr, logic [INTERVAL_W-1:0] value);
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b1, addr, APB_DATA_W'(value), rd);
		n_cfg++;
		if (addr[2] == REG_INTERVAL) begin
			interval_q = value;
			elapsed_q = ELAPSED_SAT;
		end
		apb_access(1'b0, ADDR_INTERVAL, '0, rd);
		if (rd[INTERVAL_W-1:0] !== interval_q) begin
			errors++;
			if (errors <= 10)
				$display("interval readback: exp %h got %h", interval_q, rd);
		end
	endtask

	int unsigned phase_iv[PHASES] = '{1, 3, 0, 2, 65535, 0, 6, 0, 0, 1};

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// throttling off: field extremes, tick and purge with nothing held, unused kind
		set_interval(ADDR_INTERVAL, 16'd0);
		beat_q.push_back(mk(KIND_MSG, 8'h00, 16'h0000, 16'h0000, 32'h0000_0000));
		beat_q.push_back(mk(KIND_MSG, 8'hff, 16'hffff, 16'hffff, 32'hffff_ffff));
		beat_q.push_back(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_PURGE, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_UNUSED, 8'hff, 16'hffff, 16'hffff, 32'hffff_ffff));
		settle();

		// interval two: first passes, duplicate overwrite, differing key flushes the held one,
		// release on tick, purge, pass once elapsed
		set_interval(ADDR_INTERVAL, 16'd2);
		beat_q.push_back(mk(KIND_MSG, 8'h11, 16'h0101, 16'h0a0a, 32'h1111_0001));
		beat_q.push_back(mk(KIND_MSG, 8'h22, 16'h0202, 16'h0b0b, 32'h2222_0001));
		beat_q.push_back(mk(KIND_MSG, 8'h22, 16'h0202, 16'h0b0b, 32'h2222_0002));
		beat_q.push_back(mk(KIND_MSG, 8'h33, 16'h0202, 16'h0b0b, 32'h3333_0001));
		beat_q.push_back(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_MSG, 8'h44, 16'h0404, 16'h0c0c, 32'h4444_0001));
		beat_q.push_back(mk(KIND_PURGE, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_MSG, 8'h55, 16'h0505, 16'h0d0d, 32'h5555_0001));
		beat_q.push_back(mk(KIND_MSG, 8'h66, 16'h0606, 16'h0e0e, 32'h6666_0001));
		settle();

		// throttling switched off with a message held: direct pass, then the tick releases it
		set_interval(ADDR_INTERVAL, 16'd0);
		beat_q.push_back(mk(KIND_MSG, 8'h77, 16'h0707, 16'h0f0f, 32'h7777_0001));
		beat_q.push_back(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0));
		settle();

		// unmapped register write is ignored, then the widest interval with a saturated counter
		set_interval(ADDR_UNMAPPED, 16'h1234);
		set_interval(ADDR_INTERVAL, 16'hffff);
		beat_q.push_back(mk(KIND_MSG, 8'h81, 16'h8181, 16'h8282, 32'h8888_0001));
		beat_q.push_back(mk(KIND_MSG, 8'h82, 16'h8181, 16'h8282, 32'h8888_0002));
		beat_q.push_back(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0));
		beat_q.push_back(mk(KIND_MSG, 8'h82, 16'h8180, 16'h8282, 32'h8888_0003));
		beat_q.push_back(mk(KIND_PURGE, 8'h00, 16'h0000, 16'h0000, 32'h0));
		settle();

		// random phases, each with its own interval and key pool; each phase boundary
		// pauses the sender until every expected result has arrived
		phase_iv[7] = $urandom_range(1, 65535);
		phase_iv[8] = $urandom_range(1, 8);
		for (int p = 0; p < PHASES; p++) begin
			for (int i = 0; i < 4; i++)
				key_pool[2'(i)] = random_msg();
			set_interval(ADDR_INTERVAL, phase_iv[4'(p)][INTERVAL_W-1:0]);
			for (int i = 0; i < BEATS_PER_PHASE; i++)
				beat_q.push_back(random_beat());
			// long receiver hold-off while the sender keeps offering, so the block backs up
			if (p == 2 || p == 9)
				hold_requests <= hold_requests + 1;
			settle();
		end

		repeat (10) @(posedge clk);
		errors += fwd_expect.size();
		$display("covered %0d beats over %0d register writes, %0d results (%0d direct, %0d held)",
			n_beats, n_cfg, n_results, n_direct, n_held);
		$display("input held off by the block on %0d cycles, %0d long receiver hold-offs",
			n_backpressure, holds_served);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

>>> files.f
+incdir+design
design/mtc_pkg.sv
design/mtc_cfg.sv
design/mtc_core.sv
design/message_throttle_coalescer_unit.sv
dv/testbench.sv
